>>> hdl/sida_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package sida_pkg;

   // ASCII codes that the converter emits.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] DIGIT_MAX  = 8'd9;

   // Buffer size after reset, in characters including the terminator.
   localparam logic [7:0] BUFFER_SIZE_RESET = 8'd12;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic convert_step;
      logic measure;
      logic emit_sign;
      logic emit_digit;
      logic emit_term;
      logic emit_error;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic convert_last;
      logic fits;
      logic negative;
      logic digit_last;
   } dp_status_type;

endpackage

>>> hdl/sida_ctrl.sv
// Controller state machine that sequences conversion and character output.
`timescale 1ns / 1ps

module sida_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sida_pkg::dp_status_type status,
   output sida_pkg::dp_cmd_type    cmd
);
   import sida_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_CONVERT = 7'b0000010,
      ST_MEASURE = 7'b0000100,
      ST_SIGN    = 7'b0001000,
      ST_DIGITS  = 7'b0010000,
      ST_TERM    = 7'b0100000,
      ST_ERROR   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.convert_step = 1'b1;
            if (status.convert_last) begin
               state_in = ST_MEASURE;
            end
         end
         ST_MEASURE: begin
            cmd.measure = 1'b1;
            if (!status.fits) begin
               state_in = ST_ERROR;
            end else if (status.negative) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_SIGN: begin
            cmd.emit_sign = 1'b1;
            state_in      = ST_DIGITS;
         end
         ST_DIGITS: begin
            cmd.emit_digit = 1'b1;
            if (status.digit_last) begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            cmd.emit_term = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_ERROR: begin
            cmd.emit_error = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef SYNTHESIS
   // The block only goes idle after finishing a word with a terminator or an error.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> ($past(cmd.emit_term) || $past(cmd.emit_error)))
      else $error("busy fell without a final word");

   // An error word is only emitted after a failed size check.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_error |-> ($past(cmd.measure) && !$past(status.fits)))
      else $error("error word without failed size check");

   // Conversion ends in the measure step.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.convert_step && status.convert_last) |=> cmd.measure)
      else $error("conversion did not end in measure");
`endif

endmodule

>>> hdl/sida_dp.sv
// Datapath: magnitude, binary to BCD conversion, size check and output words.
`timescale 1ns / 1ps

module sida_dp #(
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sida_pkg::dp_cmd_type          cmd,
   output sida_pkg::dp_status_type       status,
   input  logic signed [VALUE_BITS-1:0]  req_signed_value,
   input  logic                          csr_write_enable,
   input  logic [7:0]                    csr_write_data,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_ascii_char,
   output logic                          rsp_is_last,
   output logic                          rsp_overflow_error
);
   import sida_pkg::*;

   // Two magnitude bits are shifted into the BCD register per cycle.
   localparam int MAG_STEPS  = (VALUE_BITS + 1) / 2;
   localparam int MAG_W      = 2 * MAG_STEPS;
   localparam int STEP_W     = $clog2(MAG_STEPS);
   // Decimal digits of the largest magnitude, 2**(VALUE_BITS-1).
   localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
   localparam int TOT_W      = 9;

   logic [MAG_W-1:0]     mag_ff, mag_in, mag_step;
   logic [BCD_W-1:0]     bcd_ff, bcd_in, bcd_step;
   logic                 negative_ff, negative_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIG_IDX_W-1:0] digit_idx_ff, digit_idx_in;
   logic [7:0]           buffer_size_ff, buffer_size_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_error_ff, rsp_error_in;

   logic [VALUE_BITS-1:0] value_bits;
   logic [VALUE_BITS-1:0] value_abs;
   logic [DIG_CNT_W-1:0]  digit_count;
   logic [TOT_W-1:0]      text_total;
   logic [3:0]            cur_digit;

   // Unsigned magnitude of the input; the most negative value maps exactly.
   assign value_bits = req_signed_value;
   assign value_abs  = value_bits[VALUE_BITS-1] ? (~value_bits + 1'b1) : value_bits;

   // Two shift-and-add-3 iterations, one per magnitude bit.
   always_comb begin
      bcd_step = bcd_ff;
      mag_step = mag_ff;
      for (int s = 0; s < 2; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_step[d*4 +: 4] >= 4'd5) begin
               bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
            end
         end
         bcd_step = {bcd_step[BCD_W-2:0], mag_step[MAG_W-1]};
         mag_step = {mag_step[MAG_W-2:0], 1'b0};
      end
   end

   // Count of significant digits; zero still has one digit.
   always_comb begin
      digit_count = DIG_CNT_W'(1);
      for (int d = 1; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            digit_count = DIG_CNT_W'(d + 1);
         end
      end
   end

   // Digits plus sign plus terminator must fit the buffer.
   assign text_total = TOT_W'(digit_count) + TOT_W'(negative_ff) + TOT_W'(1);
   assign cur_digit  = bcd_ff[digit_idx_ff*4 +: 4];

   assign status.convert_last = (step_ff == STEP_W'(MAG_STEPS - 1));
   assign status.fits         = (buffer_size_ff > 8'd1) &&
                                (text_total <= TOT_W'(buffer_size_ff));
   assign status.negative     = negative_ff;
   assign status.digit_last   = (digit_idx_ff == '0);

   // Working registers.
   always_comb begin
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      negative_in  = negative_ff;
      step_in      = step_ff;
      digit_idx_in = digit_idx_ff;
      priority if (cmd.load) begin
         mag_in      = MAG_W'(value_abs);
         bcd_in      = '0;
         negative_in = value_bits[VALUE_BITS-1];
         step_in     = '0;
      end else if (cmd.convert_step) begin
         mag_in  = mag_step;
         bcd_in  = bcd_step;
         step_in = step_ff + 1'b1;
      end else if (cmd.measure) begin
         digit_idx_in = DIG_IDX_W'(digit_count - 1'b1);
      end else if (cmd.emit_digit) begin
         digit_idx_in = digit_idx_ff - 1'b1;
      end else begin
         // No working command: every register keeps its value.
         digit_idx_in = digit_idx_ff;
      end
   end

   // Buffer size register.
   assign buffer_size_in = csr_write_enable ? csr_write_data : buffer_size_ff;

   // Output word register.
   always_comb begin
      rsp_strobe_in = cmd.emit_sign | cmd.emit_digit | cmd.emit_term | cmd.emit_error;
      rsp_last_in   = cmd.emit_term | cmd.emit_error;
      rsp_error_in  = cmd.emit_error;
      priority if (cmd.emit_sign) begin
         rsp_char_in = CHAR_MINUS;
      end else if (cmd.emit_digit) begin
         rsp_char_in = CHAR_ZERO + {4'd0, cur_digit};
      end else begin
         rsp_char_in = CHAR_NUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= BUFFER_SIZE_RESET;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         buffer_size_ff <= buffer_size_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      bcd_ff       <= bcd_in;
      negative_ff  <= negative_in;
      step_ff      <= step_in;
      digit_idx_ff <= digit_idx_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_ascii_char     = rsp_char_ff;
   assign rsp_is_last        = rsp_last_ff;
   assign rsp_overflow_error = rsp_error_ff;

`ifndef SYNTHESIS
   // An error word is a last word carrying the NUL character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_overflow_error) |-> (rsp_is_last && rsp_ascii_char == CHAR_NUL))
      else $error("error word malformed");

   // Non-final words are a minus sign or a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_is_last) |->
         (rsp_ascii_char == CHAR_MINUS ||
          (rsp_ascii_char >= CHAR_ZERO && rsp_ascii_char <= CHAR_ZERO + DIGIT_MAX)))
      else $error("unexpected character word");

   // The leading emitted digit is never zero unless it is the only digit.
   assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.measure) && !status.digit_last) |-> (cur_digit != 4'd0))
      else $error("leading zero digit");
`endif

endmodule

>>> hdl/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

// Converts one signed VALUE_BITS-bit value into its decimal text, one ASCII
// character per output word, most significant first, with a leading '-' for
// negative values and a NUL terminator flagged by rsp_is_last.
// Input: a value on req_signed_value is taken at a clock edge where start is
// high and busy is low. Output: each word is valid for one cycle while
// rsp_strobe is high; the receiver cannot stall, so words are never held.
// If the text including terminator does not fit csr buffer size (or the size
// is at most 1), a single word with rsp_overflow_error and rsp_is_last set and
// a NUL character is emitted instead.
// Sequence: the magnitude is converted to BCD two bits per cycle, then a measure
// step checks the length, then one word leaves per cycle. A new value is taken
// only once the controller is idle again after the terminator or error word.
// The buffer size is written through csr_write_enable; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset sets the buffer size to 12 and returns the controller to idle.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [VALUE_BITS-1:0] req_signed_value,
   input  logic                         csr_write_enable,
   input  logic [7:0]                   csr_write_data,
   output logic                         rsp_strobe,
   output logic [7:0]                   rsp_ascii_char,
   output logic                         rsp_is_last,
   output logic                         rsp_overflow_error
);
   import sida_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   sida_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Conversion and output datapath.
   sida_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_signed_value   (req_signed_value),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_ascii_char     (rsp_ascii_char),
      .rsp_is_last        (rsp_is_last),
      .rsp_overflow_error (rsp_overflow_error)
   );

endmodule
